// File: hdl/ttyld_pkg.sv
// Shared types and constants for the tty line discipline block.
// No dependencies; compiled first.
`default_nettype none

package ttyld_pkg;

    localparam int unsigned MAX_READ_LEN_DEF = 4096;
    localparam int unsigned QUEUE_DEPTH      = 4;

    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 13;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_KEY   = 2'd0,
        CMD_HOST  = 2'd1,
        CMD_START = 2'd2
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_CONSOLE  = 2'd0,
        KIND_STORE    = 2'd1,
        KIND_COMPLETE = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPAND_LF = 3'd0,
        CFG_MAP_CR    = 3'd1,
        CFG_ECHO      = 3'd2,
        CFG_RAW_BS    = 3'd3,
        CFG_LINE_MODE = 3'd4
    } t_cfg_idx;

    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BS = 8'd8;

    // job mask bits, emitted lowest first
    localparam int JOB_ECHO_CR = 0;
    localparam int JOB_ECHO    = 1;
    localparam int JOB_STORE   = 2;
    localparam int JOB_DONE    = 3;
    localparam int JOB_BITS    = 4;

    typedef struct packed {
        logic [JOB_BITS-1:0] mask;
        logic [CHAR_W-1:0]   ch;
        logic [IDX_W-1:0]    idx;
        logic [CNT_W-1:0]    cnt;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_push;

    typedef struct packed {
        logic expand_lf;
        logic map_cr;
        logic echo;
        logic raw_bs;
        logic line_mode;
    } t_cfg;

endpackage

`default_nettype wire

// File: hdl/ttyld_if.sv
// Channel interfaces for the tty line discipline: request, result, config write.
// Depends on ttyld_pkg for field widths.
`default_nettype none

interface ttyld_in_if;
    logic                          valid;
    logic                          ready;
    logic [ttyld_pkg::CMD_W-1:0]   command;
    logic [ttyld_pkg::CHAR_W-1:0]  data_byte;
    logic [ttyld_pkg::CNT_W-1:0]   request_length;
    modport source (output valid, command, data_byte, request_length, input ready);
    modport sink   (input valid, command, data_byte, request_length, output ready);
endinterface

interface ttyld_out_if;
    logic                          valid;
    logic                          ready;
    logic [ttyld_pkg::KIND_W-1:0]  kind;
    logic [ttyld_pkg::CHAR_W-1:0]  char_out;
    logic [ttyld_pkg::IDX_W-1:0]   store_index;
    logic [ttyld_pkg::CNT_W-1:0]   read_count;
    logic                          last;
    modport source (output valid, kind, char_out, store_index, read_count, last,
                    input ready);
    modport sink   (input valid, kind, char_out, store_index, read_count, last,
                    output ready);
endinterface

interface ttyld_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ttyld_pkg::CFG_IDX_W-1:0]  index;
    logic                             data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/ttyld_front.sv
// Front end: config registers, read state, and classification of each request
// into a job mask. Depends on ttyld_pkg and ttyld_if.
`default_nettype none

module ttyld_front #(
    parameter int unsigned MAX_READ_LEN = ttyld_pkg::MAX_READ_LEN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ttyld_in_if.sink         i_req,
    ttyld_cfg_if.sink        i_cfg,
    input  wire logic        i_q_full,
    output ttyld_pkg::t_push o_push
);

    localparam int CW = $clog2(MAX_READ_LEN + 1);

    ttyld_pkg::t_cfg r_cfg;
    logic            r_active, n_active;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_limit, n_limit;

    logic                          accept;
    logic [ttyld_pkg::CHAR_W-1:0]  key;
    logic [CW-1:0]                 req_sat;
    logic [CW-1:0]                 cnt_inc;
    logic                          erase;
    logic                          done;

    assign i_req.ready = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_req.valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expand_lf <= 1'b1;
            r_cfg.map_cr    <= 1'b1;
            r_cfg.echo      <= 1'b1;
            r_cfg.raw_bs    <= 1'b0;
            r_cfg.line_mode <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ttyld_pkg::CFG_EXPAND_LF: r_cfg.expand_lf <= i_cfg.data;
                ttyld_pkg::CFG_MAP_CR:    r_cfg.map_cr    <= i_cfg.data;
                ttyld_pkg::CFG_ECHO:      r_cfg.echo      <= i_cfg.data;
                ttyld_pkg::CFG_RAW_BS:    r_cfg.raw_bs    <= i_cfg.data;
                ttyld_pkg::CFG_LINE_MODE: r_cfg.line_mode <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(i_req.request_length) > 32'(MAX_READ_LEN)) begin
            req_sat = CW'(MAX_READ_LEN);
        end else begin
            req_sat = CW'(i_req.request_length);
        end
        key = (i_req.data_byte == ttyld_pkg::CH_CR && r_cfg.map_cr) ?
              ttyld_pkg::CH_LF : i_req.data_byte;
        cnt_inc = r_count + CW'(1);
        erase = (key == ttyld_pkg::CH_BS) && (r_count != '0) && !r_cfg.raw_bs;
        done  = (cnt_inc >= r_limit) || (key == ttyld_pkg::CH_LF && r_cfg.line_mode);

        n_active = r_active;
        n_count  = r_count;
        n_limit  = r_limit;
        o_push   = '0;
        o_push.job.ch = i_req.data_byte;

        if (accept) begin
            case (i_req.command)
                ttyld_pkg::CMD_START: begin
                    n_count = '0;
                    if (req_sat == '0) begin
                        n_active = 1'b0;
                        n_limit  = '0;
                        o_push.job.mask[ttyld_pkg::JOB_DONE] = 1'b1;
                    end else begin
                        n_active = 1'b1;
                        n_limit  = req_sat;
                    end
                end
                ttyld_pkg::CMD_HOST: begin
                    o_push.job.mask[ttyld_pkg::JOB_ECHO] = 1'b1;
                    o_push.job.mask[ttyld_pkg::JOB_ECHO_CR] =
                        (i_req.data_byte == ttyld_pkg::CH_LF) && r_cfg.expand_lf;
                end
                ttyld_pkg::CMD_KEY: begin
                    if (r_active) begin
                        o_push.job.ch = key;
                        o_push.job.mask[ttyld_pkg::JOB_ECHO] = r_cfg.echo;
                        o_push.job.mask[ttyld_pkg::JOB_ECHO_CR] =
                            r_cfg.echo && (key == ttyld_pkg::CH_LF) && r_cfg.expand_lf;
                        if (erase) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            o_push.job.mask[ttyld_pkg::JOB_STORE] = 1'b1;
                            o_push.job.idx = ttyld_pkg::IDX_W'(r_count);
                            n_count = cnt_inc;
                            if (done) begin
                                o_push.job.mask[ttyld_pkg::JOB_DONE] = 1'b1;
                                o_push.job.cnt = ttyld_pkg::CNT_W'(cnt_inc);
                                n_active = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        o_push.push = o_push.job.mask != '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_count  <= '0;
            r_limit  <= '0;
        end else begin
            r_active <= n_active;
            r_count  <= n_count;
            r_limit  <= n_limit;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ttyld_queue.sv
// Short job queue between front and back end.
// Depends on ttyld_pkg for the job type and depth.
`default_nettype none

module ttyld_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ttyld_pkg::t_push i_push,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output ttyld_pkg::t_job       o_job
);

    localparam int DEPTH = ttyld_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);

    ttyld_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [FW-1:0]   r_fill;
    logic            do_push, do_pop;

    assign o_full  = r_fill == FW'(DEPTH);
    assign o_valid = r_fill != '0;
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_fill <= r_fill + FW'(do_push) - FW'(do_pop);
        end
    end

endmodule

`default_nettype wire

// File: hdl/ttyld_back.sv
// Back end: expands each job into console, store and complete results, one per
// cycle unless stalled, into a result register. Depends on ttyld_pkg, ttyld_if.
`default_nettype none

module ttyld_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire ttyld_pkg::t_job i_q_job,
    output logic                 o_pop,
    ttyld_out_if.source          o_rsp
);

    localparam int NB = ttyld_pkg::JOB_BITS;

    ttyld_pkg::t_job             r_job, n_job;
    logic [NB-1:0]               r_pend, n_pend;
    logic [NB-1:0]               low, rem;
    logic                        adv;

    logic                          r_valid;
    logic [ttyld_pkg::KIND_W-1:0]  r_kind;
    logic [ttyld_pkg::CHAR_W-1:0]  r_char;
    logic [ttyld_pkg::IDX_W-1:0]   r_idx;
    logic [ttyld_pkg::CNT_W-1:0]   r_cnt;
    logic                          r_last;

    assign adv = !r_valid || o_rsp.ready;
    assign low = r_pend & (~r_pend + NB'(1));
    assign rem = r_pend & ~low;

    always_comb begin
        n_pend = adv ? rem : r_pend;
        n_job  = r_job;
        o_pop  = (n_pend == '0) && i_q_valid;
        if (o_pop) begin
            n_pend = i_q_job.mask;
            n_job  = i_q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        if (adv) begin
            r_last <= rem == '0;
            r_kind <= ttyld_pkg::KIND_CONSOLE;
            r_char <= '0;
            r_idx  <= '0;
            r_cnt  <= '0;
            if (r_pend[ttyld_pkg::JOB_ECHO_CR]) begin
                r_char <= ttyld_pkg::CH_CR;
            end else if (r_pend[ttyld_pkg::JOB_ECHO]) begin
                r_char <= r_job.ch;
            end else if (r_pend[ttyld_pkg::JOB_STORE]) begin
                r_kind <= ttyld_pkg::KIND_STORE;
                r_char <= r_job.ch;
                r_idx  <= r_job.idx;
            end else begin
                r_kind <= ttyld_pkg::KIND_COMPLETE;
                r_cnt  <= r_job.cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (adv) begin
                r_valid <= r_pend != '0;
            end
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.kind        = r_kind;
    assign o_rsp.char_out    = r_char;
    assign o_rsp.store_index = r_idx;
    assign o_rsp.read_count  = r_cnt;
    assign o_rsp.last        = r_last;

endmodule

`default_nettype wire

// File: hdl/tty_line_discipline_unit.sv
// Canonical-input tty line discipline for one terminal: top level.
// Depends on ttyld_pkg, ttyld_if, ttyld_front, ttyld_queue, ttyld_back.
//
// Requests are taken one per cycle while the four-entry job queue has room;
// the front end updates the read state at once, so requests may follow back
// to back. Each request yields zero to four results (echo CR, echo or host
// character, buffer store, read complete) which the back end sends one per
// cycle while output is not stalled, through a registered output stage;
// in an idle block the first result of a request passes through the job
// queue, the back end pending register and the output stage. Config writes
// are always ready and should be issued only while no results are outstanding.
`default_nettype none

module tty_line_discipline_unit #(
    parameter int unsigned MAX_READ_LEN = ttyld_pkg::MAX_READ_LEN_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ttyld_in_if.sink    i_req,
    ttyld_cfg_if.sink   i_cfg,
    ttyld_out_if.source o_rsp
);

    ttyld_pkg::t_push push;
    ttyld_pkg::t_job  q_job;
    logic             q_full, q_valid, q_pop;

    ttyld_front #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push)
    );

    ttyld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    ttyld_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_pop     (q_pop),
        .o_rsp     (o_rsp)
    );

endmodule

`default_nettype wire

// File: hdl/ttyld_checker.sv
// Port-level checks on the tty line discipline result channel, and the bind
// that attaches them to the top level. Depends on ttyld_pkg.
`default_nettype none

module ttyld_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          i_ready,
    input wire logic [ttyld_pkg::KIND_W-1:0]  i_kind,
    input wire logic [ttyld_pkg::CHAR_W-1:0]  i_char,
    input wire logic [ttyld_pkg::IDX_W-1:0]   i_idx,
    input wire logic [ttyld_pkg::CNT_W-1:0]   i_cnt,
    input wire logic                          i_last
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_kind) && $stable(i_char) && $stable(i_idx)
                                && $stable(i_cnt) && $stable(i_last))
        else $error("result payload changed while stalled");

    a_complete_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == ttyld_pkg::KIND_COMPLETE |-> i_last)
        else $error("read complete not marked last");

    a_store_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_kind == ttyld_pkg::KIND_STORE && !i_last
        |=> i_valid && i_kind == ttyld_pkg::KIND_COMPLETE)
        else $error("non-final store not followed by read complete");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

endmodule

bind tty_line_discipline_unit ttyld_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_rsp.valid),
    .i_ready (o_rsp.ready),
    .i_kind  (o_rsp.kind),
    .i_char  (o_rsp.char_out),
    .i_idx   (o_rsp.store_index),
    .i_cnt   (o_rsp.read_count),
    .i_last  (o_rsp.last)
);

`default_nettype wire
